@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/drp_pkg.sv @@
// Shared types and constants for the DNS response parser.
// No dependencies; used by every module of the block.
package drp_pkg;

    localparam int RESULT_SLOTS = 8;
    localparam int NAME_CHARS   = 64;
    localparam int SLOT_CNT_W   = $clog2(RESULT_SLOTS + 1);

    // Result queue, depth must be a power of two and at least 4.
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_PUSH     = 3;

    localparam logic [SLOT_CNT_W-1:0] SLOTS_MAX = SLOT_CNT_W'(RESULT_SLOTS);
    localparam logic [6:0]            NCC_LIMIT = 7'(NAME_CHARS - 1);

    localparam logic [7:0]  PTR_MASK   = 8'hc0;
    localparam logic [15:0] TYPE_A     = 16'h0001;
    localparam logic [15:0] TYPE_CNAME = 16'h0005;
    localparam logic [15:0] CLASS_IN   = 16'h0001;
    localparam logic [7:0]  DOT_CHAR   = 8'h2e;

    localparam logic [1:0] KIND_ADDR = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Name sub-states held in the field counter while in a name phase.
    localparam logic [3:0] NM_FIRST     = 4'd0;
    localparam logic [3:0] NM_LABELS    = 4'd1;
    localparam logic [3:0] NM_PTR_ALIAS = 4'd2;
    localparam logic [3:0] NM_PTR_SKIP  = 4'd3;

    typedef enum logic [9:0] {
        PH_HEADER      = 10'b00_0000_0001,
        PH_QNAME       = 10'b00_0000_0010,
        PH_QTAIL       = 10'b00_0000_0100,
        PH_ANAME       = 10'b00_0000_1000,
        PH_AFIXED      = 10'b00_0001_0000,
        PH_RDATA_A     = 10'b00_0010_0000,
        PH_RDATA_CNAME = 10'b00_0100_0000,
        PH_RDATA_SKIP  = 10'b00_1000_0000,
        PH_DONE        = 10'b01_0000_0000,
        PH_REJECTED    = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ipv4_address;
        logic [7:0]  name_char;
        logic [5:0]  slot_index;
        logic [1:0]  status;
        logic [6:0]  alias_total;
        logic [6:0]  address_total;
    } t_result;

    // Results of one byte, in delivery order; unused entries have valid low.
    typedef struct packed {
        logic [MAX_PUSH-1:0]          valid;
        t_result [MAX_PUSH-1:0]       item;
    } t_result_set;

endpackage

@@ hdl/dns_response_parser_top.sv @@
// DNS response parser: one message byte per transfer, name/address results out.
// A byte's results enter the result queue at its transfer; the queue head drives the output.
// Throughput: one byte per cycle while the result queue is not full; a byte yields at most three results.
// Input stall is taken from the registered queue fill level, so it never waits on i_stall.
// Reset (i_rst_n low, synchronous) returns the parser to the header phase and empties the queue.
// Depends on drp_pkg, drp_parse and drp_queue.
module dns_response_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_ipv4_address,
    output logic [7:0]  o_name_char,
    output logic [5:0]  o_slot_index,
    output logic [1:0]  o_status,
    output logic [6:0]  o_alias_total,
    output logic [6:0]  o_address_total
);

    logic                 in_xfer;
    logic                 q_full;
    drp_pkg::t_result_set results;
    drp_pkg::t_result     head;

    // A byte is consumed whenever the queue can absorb its worst case.
    assign o_stall = q_full;
    assign in_xfer = i_valid && !q_full;

    // Parse state advances on every byte transfer; results are combinational
    // off the current state and the incoming byte.
    drp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_msg_byte  (i_msg_byte),
        .i_last_byte (i_last_byte),
        .o_results   (results)
    );

    // Results land in the queue at the same edge; the head is the output register.
    drp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (in_xfer),
        .i_results (results),
        .i_pop     (!i_stall),
        .o_valid   (o_valid),
        .o_full    (q_full),
        .o_head    (head)
    );

    assign o_kind          = head.kind;
    assign o_ipv4_address  = head.ipv4_address;
    assign o_name_char     = head.name_char;
    assign o_slot_index    = head.slot_index;
    assign o_status        = head.status;
    assign o_alias_total   = head.alias_total;
    assign o_address_total = head.address_total;

endmodule

@@ hdl/drp_parse.sv @@
// Byte-wide DNS response parse state and next-state logic.
// Depends on drp_pkg; feeds up to three results per byte to the result queue.
module drp_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_msg_byte,
    input  logic                 i_last_byte,
    output drp_pkg::t_result_set o_results
);

    drp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_fc, n_fc;
    logic [15:0] r_qc, n_qc;
    logic [15:0] r_ac, n_ac;
    logic [15:0] r_type, n_type;
    logic [15:0] r_class, n_class;
    logic [15:0] r_rr, n_rr;
    logic [31:0] r_shift, n_shift;
    logic [7:0]  r_lr, n_lr;
    logic [6:0]  r_ncc, n_ncc;
    logic [drp_pkg::SLOT_CNT_W-1:0] r_alias, n_alias;
    logic [drp_pkg::SLOT_CNT_W-1:0] r_addr, n_addr;
    logic        r_ovf, n_ovf;

    // One name byte, evaluated on the current state.
    logic [3:0]  nb_fc;
    logic [7:0]  nb_lr;
    logic [6:0]  nb_ncc;
    logic [drp_pkg::SLOT_CNT_W-1:0] nb_alias;
    logic        nb_ovf;
    logic        nb_done;
    logic        nb_first;
    drp_pkg::t_result nb_res;
    logic        nb_res_v;

    logic        rec_done;
    logic [1:0]  done_status;
    drp_pkg::t_result_set res;

    always_comb begin
        nb_fc    = r_fc;
        nb_lr    = r_lr;
        nb_ncc   = r_ncc;
        nb_alias = r_alias;
        nb_ovf   = r_ovf;
        nb_done  = 1'b0;
        nb_first = (r_fc == drp_pkg::NM_FIRST);
        nb_res   = '0;
        nb_res_v = 1'b0;
        if (r_fc == drp_pkg::NM_PTR_ALIAS || r_fc == drp_pkg::NM_PTR_SKIP) begin
            // pointer low byte ends the name
            nb_done = 1'b1;
            if (r_fc == drp_pkg::NM_PTR_ALIAS && r_alias < drp_pkg::SLOTS_MAX) begin
                nb_res_v          = 1'b1;
                nb_res.kind       = drp_pkg::KIND_END;
                nb_res.slot_index = 6'(r_alias);
                nb_alias          = r_alias + 1'b1;
            end
        end else if (r_lr != 8'd0) begin
            if (r_alias < drp_pkg::SLOTS_MAX && r_ncc < drp_pkg::NCC_LIMIT) begin
                nb_res_v          = 1'b1;
                nb_res.kind       = drp_pkg::KIND_CHAR;
                nb_res.name_char  = i_msg_byte;
                nb_res.slot_index = 6'(r_alias);
                nb_ncc            = r_ncc + 1'b1;
            end
            nb_lr = r_lr - 1'b1;
        end else if ((i_msg_byte & drp_pkg::PTR_MASK) == drp_pkg::PTR_MASK) begin
            nb_fc = nb_first ? drp_pkg::NM_PTR_SKIP : drp_pkg::NM_PTR_ALIAS;
        end else begin
            if (nb_first && r_alias >= drp_pkg::SLOTS_MAX) begin
                nb_ovf = 1'b1;
            end
            if (i_msg_byte == 8'd0) begin
                nb_done = 1'b1;
                if (r_alias < drp_pkg::SLOTS_MAX) begin
                    nb_res_v          = 1'b1;
                    nb_res.kind       = drp_pkg::KIND_END;
                    nb_res.slot_index = 6'(r_alias);
                    nb_alias          = r_alias + 1'b1;
                end
            end else begin
                if (!nb_first && r_alias < drp_pkg::SLOTS_MAX &&
                    r_ncc < drp_pkg::NCC_LIMIT) begin
                    nb_res_v          = 1'b1;
                    nb_res.kind       = drp_pkg::KIND_CHAR;
                    nb_res.name_char  = drp_pkg::DOT_CHAR;
                    nb_res.slot_index = 6'(r_alias);
                    nb_ncc            = r_ncc + 1'b1;
                end
                nb_lr = i_msg_byte;
                nb_fc = drp_pkg::NM_LABELS;
            end
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_fc     = r_fc;
        n_qc     = r_qc;
        n_ac     = r_ac;
        n_type   = r_type;
        n_class  = r_class;
        n_rr     = r_rr;
        n_shift  = r_shift;
        n_lr     = r_lr;
        n_ncc    = r_ncc;
        n_alias  = r_alias;
        n_addr   = r_addr;
        n_ovf    = r_ovf;
        rec_done = 1'b0;
        res      = '0;
        done_status = drp_pkg::ST_OK;

        unique case (r_phase) inside
            drp_pkg::PH_HEADER: begin
                if (r_fc == 4'd4 || r_fc == 4'd5) begin
                    n_qc = {r_qc[7:0], i_msg_byte};
                end
                if (r_fc == 4'd6 || r_fc == 4'd7) begin
                    n_ac = {r_ac[7:0], i_msg_byte};
                end
                n_fc = r_fc + 1'b1;
                if (n_fc == 4'd12) begin
                    if (n_ac == 16'd0 || n_qc > 16'd1) begin
                        n_phase = drp_pkg::PH_REJECTED;
                    end else begin
                        n_phase = drp_pkg::PH_QNAME;
                        n_fc    = drp_pkg::NM_FIRST;
                        n_lr    = 8'd0;
                        n_ncc   = 7'd0;
                    end
                end
            end
            drp_pkg::PH_QNAME, drp_pkg::PH_ANAME: begin
                n_fc    = nb_fc;
                n_lr    = nb_lr;
                n_ncc   = nb_ncc;
                n_alias = nb_alias;
                n_ovf   = nb_ovf;
                res.valid[0] = nb_res_v;
                res.item[0]  = nb_res;
                if (nb_done) begin
                    n_phase = (r_phase == drp_pkg::PH_QNAME) ?
                              drp_pkg::PH_QTAIL : drp_pkg::PH_AFIXED;
                    n_fc    = 4'd0;
                end
            end
            drp_pkg::PH_QTAIL: begin
                n_fc = r_fc + 1'b1;
                if (n_fc == 4'd4) begin
                    n_phase = drp_pkg::PH_ANAME;
                    n_fc    = drp_pkg::NM_FIRST;
                    n_lr    = 8'd0;
                    n_ncc   = 7'd0;
                end
            end
            drp_pkg::PH_AFIXED: begin
                if (r_fc < 4'd2) begin
                    n_type = {r_type[7:0], i_msg_byte};
                end else if (r_fc < 4'd4) begin
                    n_class = {r_class[7:0], i_msg_byte};
                end else if (r_fc >= 4'd8) begin
                    n_rr = {r_rr[7:0], i_msg_byte};
                end
                n_fc = r_fc + 1'b1;
                if (n_fc == 4'd10) begin
                    n_fc = 4'd0;
                    if (n_rr == 16'd0) begin
                        rec_done = 1'b1;
                    end else if (n_type == drp_pkg::TYPE_A && n_class == drp_pkg::CLASS_IN &&
                                 n_rr >= 16'd4) begin
                        n_phase = drp_pkg::PH_RDATA_A;
                        n_shift = 32'd0;
                    end else if (n_type == drp_pkg::TYPE_CNAME &&
                                 n_class == drp_pkg::CLASS_IN) begin
                        n_phase = drp_pkg::PH_RDATA_CNAME;
                        n_lr    = 8'd0;
                        n_ncc   = 7'd0;
                    end else begin
                        n_phase = drp_pkg::PH_RDATA_SKIP;
                    end
                end
            end
            drp_pkg::PH_RDATA_A: begin
                n_shift = {r_shift[23:0], i_msg_byte};
                n_fc    = r_fc + 1'b1;
                if (n_fc == 4'd4) begin
                    if (r_addr < drp_pkg::SLOTS_MAX) begin
                        res.valid[0]             = 1'b1;
                        res.item[0].kind         = drp_pkg::KIND_ADDR;
                        res.item[0].ipv4_address = n_shift;
                        res.item[0].slot_index   = 6'(r_addr);
                        n_addr = r_addr + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_phase = drp_pkg::PH_RDATA_SKIP;
                end
                n_rr = r_rr - 1'b1;
                rec_done = (n_rr == 16'd0);
            end
            drp_pkg::PH_RDATA_CNAME: begin
                n_fc    = nb_fc;
                n_lr    = nb_lr;
                n_ncc   = nb_ncc;
                n_alias = nb_alias;
                n_ovf   = nb_ovf;
                res.valid[0] = nb_res_v;
                res.item[0]  = nb_res;
                if (nb_done) begin
                    n_phase = drp_pkg::PH_RDATA_SKIP;
                end else if (r_rr == 16'd1 && nb_fc != drp_pkg::NM_PTR_SKIP) begin
                    // rdata ran out inside the target: close the name here
                    if (nb_alias < drp_pkg::SLOTS_MAX) begin
                        res.valid[1]           = 1'b1;
                        res.item[1].kind       = drp_pkg::KIND_END;
                        res.item[1].slot_index = 6'(nb_alias);
                        n_alias = nb_alias + 1'b1;
                    end
                end
                n_rr = r_rr - 1'b1;
                rec_done = (n_rr == 16'd0);
            end
            drp_pkg::PH_RDATA_SKIP: begin
                n_rr = r_rr - 1'b1;
                rec_done = (n_rr == 16'd0);
            end
            drp_pkg::PH_DONE, drp_pkg::PH_REJECTED: begin
                // trailing bytes are ignored
            end
            default: begin
            end
        endcase

        if (rec_done) begin
            n_ac = r_ac - 1'b1;
            if (n_ac == 16'd0) begin
                n_phase = drp_pkg::PH_DONE;
            end else begin
                n_phase = drp_pkg::PH_ANAME;
                n_fc    = drp_pkg::NM_FIRST;
                n_lr    = 8'd0;
                n_ncc   = 7'd0;
            end
        end

        if (i_last_byte) begin
            if (n_phase == drp_pkg::PH_REJECTED) begin
                done_status = drp_pkg::ST_REJECTED;
            end else if (n_phase != drp_pkg::PH_DONE) begin
                done_status = drp_pkg::ST_TRUNC;
            end else if (n_ovf) begin
                done_status = drp_pkg::ST_OVERFLOW;
            end else begin
                done_status = drp_pkg::ST_OK;
            end
            res.valid[2]              = 1'b1;
            res.item[2].kind          = drp_pkg::KIND_DONE;
            res.item[2].status        = done_status;
            res.item[2].alias_total   = 7'(n_alias);
            res.item[2].address_total = 7'(n_addr);
            // back to reset state for the next message
            n_phase = drp_pkg::PH_HEADER;
            n_fc    = 4'd0;
            n_qc    = 16'd0;
            n_ac    = 16'd0;
            n_type  = 16'd0;
            n_class = 16'd0;
            n_rr    = 16'd0;
            n_shift = 32'd0;
            n_lr    = 8'd0;
            n_ncc   = 7'd0;
            n_alias = '0;
            n_addr  = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= drp_pkg::PH_HEADER;
            r_fc    <= 4'd0;
            r_qc    <= 16'd0;
            r_ac    <= 16'd0;
            r_type  <= 16'd0;
            r_class <= 16'd0;
            r_rr    <= 16'd0;
            r_shift <= 32'd0;
            r_lr    <= 8'd0;
            r_ncc   <= 7'd0;
            r_alias <= '0;
            r_addr  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_qc    <= n_qc;
            r_ac    <= n_ac;
            r_type  <= n_type;
            r_class <= n_class;
            r_rr    <= n_rr;
            r_shift <= n_shift;
            r_lr    <= n_lr;
            r_ncc   <= n_ncc;
            r_alias <= n_alias;
            r_addr  <= n_addr;
            r_ovf   <= n_ovf;
        end
    end

    assign o_results = res;

endmodule

@@ hdl/drp_queue.sv @@
// Result queue: packs up to three results per byte, drains one per transfer.
// Depends on drp_pkg.
module drp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  drp_pkg::t_result_set i_results,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output drp_pkg::t_result     o_head
);

    drp_pkg::t_result r_mem [drp_pkg::QUEUE_DEPTH];
    logic [drp_pkg::QUEUE_PTR_W-1:0] r_wr, n_wr;
    logic [drp_pkg::QUEUE_PTR_W-1:0] r_rd, n_rd;
    logic [drp_pkg::QUEUE_CNT_W-1:0] r_count, n_count;
    logic [drp_pkg::QUEUE_PTR_W-1:0] wr_idx [drp_pkg::MAX_PUSH];
    logic [drp_pkg::MAX_PUSH-1:0]    wr_en;
    logic [1:0]                      off1, off2, push_cnt;
    logic                            pop_en;

    always_comb begin
        wr_en     = i_push ? i_results.valid : '0;
        off1      = {1'b0, wr_en[0]};
        off2      = off1 + {1'b0, wr_en[1]};
        push_cnt  = off2 + {1'b0, wr_en[2]};
        wr_idx[0] = r_wr;
        wr_idx[1] = r_wr + drp_pkg::QUEUE_PTR_W'(off1);
        wr_idx[2] = r_wr + drp_pkg::QUEUE_PTR_W'(off2);
        pop_en    = i_pop && (r_count != '0);
        n_wr      = r_wr + drp_pkg::QUEUE_PTR_W'(push_cnt);
        n_rd      = r_rd + drp_pkg::QUEUE_PTR_W'(pop_en);
        n_count   = r_count + drp_pkg::QUEUE_CNT_W'(push_cnt)
                  - drp_pkg::QUEUE_CNT_W'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < drp_pkg::MAX_PUSH; k++) begin
            if (wr_en[k]) begin
                r_mem[wr_idx[k]] <= i_results.item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    // room for a worst-case byte is kept at all times
    assign o_full  = (r_count >
                      drp_pkg::QUEUE_CNT_W'(drp_pkg::QUEUE_DEPTH - drp_pkg::MAX_PUSH));
    assign o_head  = r_mem[r_rd];

endmodule

@@ hdl/drp_checker.sv @@
// Port-level checks for the DNS response parser, bound to the top level.
// Depends on drp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_msg_byte,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [31:0] o_ipv4_address,
    input logic [7:0]  o_name_char,
    input logic [5:0]  o_slot_index,
    input logic [1:0]  o_status,
    input logic [6:0]  o_alias_total,
    input logic [6:0]  o_address_total
);

    `ASSERT_CLK_RST(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_ipv4_address) && $stable(o_name_char) && $stable(o_slot_index) && $stable(o_status), "stalled result changed")
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")
    `ASSERT_CLK_RST(a_fields_clean, i_clk, i_rst_n, o_valid && o_kind != drp_pkg::KIND_DONE |-> o_status == drp_pkg::ST_OK && o_alias_total == 7'd0 && o_address_total == 7'd0, "summary fields set on a non-done result")
    `ASSERT_CLK_RST(a_totals_bound, i_clk, i_rst_n, o_valid && o_kind == drp_pkg::KIND_DONE |-> o_alias_total <= 7'(drp_pkg::RESULT_SLOTS) && o_address_total <= 7'(drp_pkg::RESULT_SLOTS) && o_slot_index == 6'd0, "done totals out of range")

endmodule

bind dns_response_parser_top drp_checker u_drp_checker (.*);
